// ----- hw/rtl/vizing_edge_colorer_assert.svh -----
// ----------------------------------------------------------------------------
// Vizing edge colorer assertion macros
// Concurrent check shorthands clocked on clk, quiet while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef VIZING_EDGE_COLORER_ASSERT_SVH
`define VIZING_EDGE_COLORER_ASSERT_SVH

// Check that a property holds at every clock edge out of reset
`define VEC_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check that a condition is never seen out of reset
`define VEC_ASSERT_NEVER(lbl, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`endif

// ----- hw/rtl/vec_pkg.sv -----
// ----------------------------------------------------------------------------
// Vizing edge colorer package
// Shared defaults, action codes and status codes.
// ----------------------------------------------------------------------------
`default_nettype none

package vec_pkg;

    // Default vertex count
    localparam int DEF_MAX_VERTICES = 64;

    // Default shape of the generic RAM
    localparam int DEF_RAM_WIDTH = 8;
    localparam int DEF_RAM_DEPTH = 64;

    // Fixed field widths
    localparam int VERTEX_W = 7;
    localparam int ACTION_W = 2;
    localparam int STATUS_W = 2;

    // Action codes
    localparam logic [ACTION_W-1:0] ACT_INSERT = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_READ   = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_CLEAR  = 2'd2;
    localparam logic [ACTION_W-1:0] ACT_SPARE  = 2'd3;

    // Status codes
    localparam logic [STATUS_W-1:0] STAT_DONE   = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_REPEAT = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_REJECT = 2'd2;

endpackage

`default_nettype wire

// ----- hw/rtl/vec_ram.sv -----
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module vec_ram #(
    parameter int WIDTH = vec_pkg::DEF_RAM_WIDTH,
    parameter int DEPTH = vec_pkg::DEF_RAM_DEPTH
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write, then register the read word
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ----- hw/rtl/vizing_edge_colorer.sv -----
// ----------------------------------------------------------------------------
// Vizing edge colorer
// Incremental edge coloring with at most max degree plus one colors.
// ----------------------------------------------------------------------------
// One item is worked at a time; in_stall stays high until its result has been
// placed in the output register. Every step makes at most one read and one
// write on each two-port RAM under one sequencer, so the run time follows the
// graph: a read or a repeated insert is a lookup and a decision, a rejected
// pair or the unused action goes straight to the result, and a fresh insert
// costs, per attempt, a sweep to clear the seen marks, then fan steps, paints
// (with a free color search at one color per cycle) and path edges inverted.
// Reset and the clear action each run a clearing pass over
// 2**(2*ceil(log2(MAX_VERTICES+1))) addresses (16384 at 64 vertices) through
// the edge, neighbor, free color and seen stores; no item is taken during the
// pass after reset.
`default_nettype none
`include "vizing_edge_colorer_assert.svh"

module vizing_edge_colorer #(
    parameter int MAX_VERTICES = vec_pkg::DEF_MAX_VERTICES
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            in_valid,
    output logic                                 in_stall,
    input  wire logic [vec_pkg::ACTION_W-1:0]    action,
    input  wire logic [vec_pkg::VERTEX_W-1:0]    first_vertex,
    input  wire logic [vec_pkg::VERTEX_W-1:0]    second_vertex,
    output logic                                 out_valid,
    input  wire logic                            out_stall,
    output logic      [vec_pkg::VERTEX_W-1:0]    edge_color,
    output logic      [vec_pkg::STATUS_W-1:0]    status
);

    import vec_pkg::*;

    localparam int VSPAN     = MAX_VERTICES + 1;
    localparam int VW        = $clog2(VSPAN);
    localparam int AW        = 2 * VW;
    localparam int NW        = $clog2(VSPAN + 1);
    localparam int NCW       = $clog2(VSPAN + 2);
    localparam int MAX_TRIES = 2 * VSPAN;
    localparam int TW        = $clog2(MAX_TRIES + 1);
    localparam int NS        = 48;

    typedef enum logic [NS-1:0] {
        S_CLEAR     = NS'(1) << 0,
        S_IDLE      = NS'(1) << 1,
        S_LOOKUP    = NS'(1) << 2,
        S_DECIDE    = NS'(1) << 3,
        S_TRY_RD    = NS'(1) << 4,
        S_TRY_CHK   = NS'(1) << 5,
        S_SEEN_CLR  = NS'(1) << 6,
        S_FREE_RD   = NS'(1) << 7,
        S_FREE_GET  = NS'(1) << 8,
        S_FAN_RD    = NS'(1) << 9,
        S_FAN_CHK   = NS'(1) << 10,
        S_FAN_ADD   = NS'(1) << 11,
        S_FAN_CV    = NS'(1) << 12,
        S_FAN_DU    = NS'(1) << 13,
        S_FAN_SEEN  = NS'(1) << 14,
        S_ROT_RD    = NS'(1) << 15,
        S_ROT_PAINT = NS'(1) << 16,
        S_ROT_NEXT  = NS'(1) << 17,
        S_SHF_RD    = NS'(1) << 18,
        S_SHF_PAINT = NS'(1) << 19,
        S_SHF_NEXT  = NS'(1) << 20,
        S_POST_RD   = NS'(1) << 21,
        S_POST_CHK  = NS'(1) << 22,
        S_PATH      = NS'(1) << 23,
        S_INV_RD1   = NS'(1) << 24,
        S_INV_RD2   = NS'(1) << 25,
        S_INV_WR1   = NS'(1) << 26,
        S_INV_WR2   = NS'(1) << 27,
        S_INV_EC1   = NS'(1) << 28,
        S_INV_EC2   = NS'(1) << 29,
        S_INV_FREE  = NS'(1) << 30,
        S_FIX_RD    = NS'(1) << 31,
        S_FIX_CHK   = NS'(1) << 32,
        S_SRCH_RD   = NS'(1) << 33,
        S_SRCH_CHK  = NS'(1) << 34,
        S_ATT_END   = NS'(1) << 35,
        S_PNT_RD    = NS'(1) << 36,
        S_PNT_GET   = NS'(1) << 37,
        S_PNT_EC2   = NS'(1) << 38,
        S_PNT_NB1   = NS'(1) << 39,
        S_PNT_NB2   = NS'(1) << 40,
        S_PNT_NB3   = NS'(1) << 41,
        S_PNT_NB4   = NS'(1) << 42,
        S_PNT_LF1   = NS'(1) << 43,
        S_PNT_LF2   = NS'(1) << 44,
        S_REF_RD    = NS'(1) << 45,
        S_REF_CHK   = NS'(1) << 46,
        S_RESULT    = NS'(1) << 47
    } state_t;

    // Control registers
    state_t           state_reg, state_next;
    state_t           ret_reg, ret_next;
    logic [AW-1:0]    clr_cnt_reg, clr_cnt_next;
    logic             respond_reg, respond_next;
    logic [TW-1:0]    tries_reg, tries_next;
    logic [TW-1:0]    steps_reg, steps_next;
    logic             out_valid_reg, out_valid_next;

    // Working registers
    logic [ACTION_W-1:0] act_reg, act_next;
    logic [VW-1:0]    u_reg, u_next;
    logic [VW-1:0]    v0_reg, v0_next;
    logic [VW-1:0]    v_reg, v_next;
    logic [VW-1:0]    c0_reg, c0_next;
    logic [VW-1:0]    c_reg, c_next;
    logic [VW-1:0]    d_reg, d_next;
    logic [NCW-1:0]   n_reg, n_next;
    logic [NW-1:0]    a_reg, a_next;
    logic [VW-1:0]    x_reg, x_next;
    logic [VW-1:0]    pc_reg, pc_next;
    logic [VW-1:0]    p_reg, p_next;
    logic [VW-1:0]    t_reg, t_next;
    logic [VW-1:0]    t2_reg, t2_next;
    logic [VW-1:0]    nbud_reg, nbud_next;
    logic [VW-1:0]    rf_w_reg, rf_w_next;
    logic [VW-1:0]    rf_x_reg, rf_x_next;
    logic             second_reg, second_next;
    logic             final_reg, final_next;
    logic [VERTEX_W-1:0] res_color_reg, res_color_next;
    logic [STATUS_W-1:0] res_status_reg, res_status_next;
    logic [VERTEX_W-1:0] edge_color_reg, edge_color_next;
    logic [STATUS_W-1:0] status_reg, status_next;

    // RAM ports
    logic             ec_we, nb_we, lf_we, sn_we, fan_we;
    logic [AW-1:0]    ec_waddr, ec_raddr, nb_waddr, nb_raddr;
    logic [VW-1:0]    ec_wdata, ec_rdata, nb_wdata, nb_rdata;
    logic [VW-1:0]    lf_waddr, lf_raddr, lf_wdata, lf_rdata;
    logic [VW-1:0]    sn_waddr, sn_raddr;
    logic             sn_wdata, sn_rdata;
    logic [NW-1:0]    fan_waddr, fan_raddr;
    logic [VW-1:0]    fv_wdata, fv_rdata, fc_wdata, fc_rdata;

    logic             bad_pair;

    // Edge colors, indexed by vertex pair
    vec_ram #(.WIDTH(VW), .DEPTH(2 ** AW)) u_ec (
        .clk(clk), .we(ec_we), .waddr(ec_waddr), .wdata(ec_wdata),
        .raddr(ec_raddr), .rdata(ec_rdata)
    );

    // Neighbor of a vertex over each color
    vec_ram #(.WIDTH(VW), .DEPTH(2 ** AW)) u_nb (
        .clk(clk), .we(nb_we), .waddr(nb_waddr), .wdata(nb_wdata),
        .raddr(nb_raddr), .rdata(nb_rdata)
    );

    // Known free color of each vertex
    vec_ram #(.WIDTH(VW), .DEPTH(2 ** VW)) u_lf (
        .clk(clk), .we(lf_we), .waddr(lf_waddr), .wdata(lf_wdata),
        .raddr(lf_raddr), .rdata(lf_rdata)
    );

    // Colors already followed in the current fan
    vec_ram #(.WIDTH(1), .DEPTH(2 ** VW)) u_sn (
        .clk(clk), .we(sn_we), .waddr(sn_waddr), .wdata(sn_wdata),
        .raddr(sn_raddr), .rdata(sn_rdata)
    );

    // Fan vertices and their free colors
    vec_ram #(.WIDTH(VW), .DEPTH(VSPAN + 1)) u_fv (
        .clk(clk), .we(fan_we), .waddr(fan_waddr), .wdata(fv_wdata),
        .raddr(fan_raddr), .rdata(fv_rdata)
    );

    vec_ram #(.WIDTH(VW), .DEPTH(VSPAN + 1)) u_fc (
        .clk(clk), .we(fan_we), .waddr(fan_waddr), .wdata(fc_wdata),
        .raddr(fan_raddr), .rdata(fc_rdata)
    );

    // Flag a zero, out of range or repeated vertex
    assign bad_pair = (first_vertex == '0) || (second_vertex == '0)
                   || (int'(first_vertex) > MAX_VERTICES)
                   || (int'(second_vertex) > MAX_VERTICES)
                   || (first_vertex == second_vertex);

    assign in_stall   = (state_reg != S_IDLE);
    assign out_valid  = out_valid_reg;
    assign edge_color = edge_color_reg;
    assign status     = status_reg;

    // Sequencer
    always_comb
    begin
        state_next      = state_reg;
        ret_next        = ret_reg;
        clr_cnt_next    = clr_cnt_reg;
        respond_next    = respond_reg;
        tries_next      = tries_reg;
        steps_next      = steps_reg;
        act_next        = act_reg;
        u_next          = u_reg;
        v0_next         = v0_reg;
        v_next          = v_reg;
        c0_next         = c0_reg;
        c_next          = c_reg;
        d_next          = d_reg;
        n_next          = n_reg;
        a_next          = a_reg;
        x_next          = x_reg;
        pc_next         = pc_reg;
        p_next          = p_reg;
        t_next          = t_reg;
        t2_next         = t2_reg;
        nbud_next       = nbud_reg;
        rf_w_next       = rf_w_reg;
        rf_x_next       = rf_x_reg;
        second_next     = second_reg;
        final_next      = final_reg;
        res_color_next  = res_color_reg;
        res_status_next = res_status_reg;
        edge_color_next = edge_color_reg;
        status_next     = status_reg;
        out_valid_next  = out_valid_reg && out_stall;

        ec_we = 1'b0; ec_waddr = '0; ec_wdata = '0; ec_raddr = '0;
        nb_we = 1'b0; nb_waddr = '0; nb_wdata = '0; nb_raddr = '0;
        lf_we = 1'b0; lf_waddr = '0; lf_wdata = '0; lf_raddr = '0;
        sn_we = 1'b0; sn_waddr = '0; sn_wdata = 1'b0; sn_raddr = '0;
        fan_we = 1'b0; fan_waddr = '0; fv_wdata = '0; fc_wdata = '0;
        fan_raddr = '0;

        case (state_reg)
            // Sweep the edge, neighbor, free color and seen stores back to their empty values
            S_CLEAR:
            begin
                ec_we    = 1'b1;
                ec_waddr = clr_cnt_reg;
                nb_we    = 1'b1;
                nb_waddr = clr_cnt_reg;
                lf_we    = 1'b1;
                lf_waddr = clr_cnt_reg[VW-1:0];
                lf_wdata = VW'(1);
                sn_we    = 1'b1;
                sn_waddr = clr_cnt_reg[VW-1:0];
                clr_cnt_next = clr_cnt_reg + AW'(1);
                if (&clr_cnt_reg)
                begin
                    if (respond_reg)
                    begin
                        res_color_next  = '0;
                        res_status_next = STAT_DONE;
                        state_next      = S_RESULT;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
            end

            // Take an item and sort it out
            S_IDLE:
            begin
                if (in_valid)
                begin
                    act_next        = action;
                    u_next          = VW'(first_vertex);
                    v0_next         = VW'(second_vertex);
                    res_color_next  = '0;
                    res_status_next = STAT_DONE;
                    if (action == ACT_CLEAR)
                    begin
                        clr_cnt_next = '0;
                        respond_next = 1'b1;
                        state_next   = S_CLEAR;
                    end
                    else if (action != ACT_INSERT && action != ACT_READ)
                    begin
                        state_next = S_RESULT;
                    end
                    else if (bad_pair)
                    begin
                        res_status_next = STAT_REJECT;
                        state_next      = S_RESULT;
                    end
                    else
                    begin
                        state_next = S_LOOKUP;
                    end
                end
            end

            S_LOOKUP:
            begin
                ec_raddr   = {u_reg, v0_reg};
                state_next = S_DECIDE;
            end

            // Answer a read or a repeated insert, else start the attempts
            S_DECIDE:
            begin
                res_color_next = VERTEX_W'(ec_rdata);
                if (act_reg == ACT_READ)
                begin
                    res_status_next = STAT_DONE;
                    state_next      = S_RESULT;
                end
                else if (ec_rdata != '0)
                begin
                    res_status_next = STAT_REPEAT;
                    state_next      = S_RESULT;
                end
                else
                begin
                    tries_next = '0;
                    state_next = S_TRY_RD;
                end
            end

            S_TRY_RD:
            begin
                ec_raddr   = {u_reg, v0_reg};
                state_next = S_TRY_CHK;
            end

            S_TRY_CHK:
            begin
                if (ec_rdata != '0 || tries_reg == TW'(MAX_TRIES))
                begin
                    res_color_next  = VERTEX_W'(ec_rdata);
                    res_status_next = STAT_DONE;
                    state_next      = S_RESULT;
                end
                else
                begin
                    clr_cnt_next = '0;
                    state_next   = S_SEEN_CLR;
                end
            end

            // Drop the seen marks of the last attempt
            S_SEEN_CLR:
            begin
                sn_we        = 1'b1;
                sn_waddr     = clr_cnt_reg[VW-1:0];
                clr_cnt_next = clr_cnt_reg + AW'(1);
                if (clr_cnt_reg[VW-1:0] == VW'(MAX_VERTICES))
                begin
                    state_next = S_FREE_RD;
                end
            end

            S_FREE_RD:
            begin
                lf_raddr   = u_reg;
                state_next = S_FREE_GET;
            end

            S_FREE_GET:
            begin
                c0_next    = lf_rdata;
                c_next     = lf_rdata;
                v_next     = v0_reg;
                d_next     = '0;
                n_next     = '0;
                state_next = S_FAN_RD;
            end

            // Grow the fan one vertex per pass
            S_FAN_RD:
            begin
                ec_raddr   = {u_reg, v0_reg};
                state_next = S_FAN_CHK;
            end

            S_FAN_CHK:
            begin
                if (ec_rdata != '0 || n_reg == NCW'(VSPAN + 1))
                begin
                    state_next = S_POST_RD;
                end
                else
                begin
                    lf_raddr   = v_reg;
                    state_next = S_FAN_ADD;
                end
            end

            S_FAN_ADD:
            begin
                d_next     = lf_rdata;
                fan_we     = 1'b1;
                fan_waddr  = NW'(n_reg);
                fv_wdata   = v_reg;
                fc_wdata   = lf_rdata;
                n_next     = n_reg + NCW'(1);
                nb_raddr   = {v_reg, c_reg};
                state_next = S_FAN_CV;
            end

            S_FAN_CV:
            begin
                if (nb_rdata == '0)
                begin
                    a_next     = NW'(n_reg - NCW'(1));
                    state_next = S_ROT_RD;
                end
                else
                begin
                    nb_raddr   = {u_reg, d_reg};
                    state_next = S_FAN_DU;
                end
            end

            S_FAN_DU:
            begin
                if (nb_rdata == '0)
                begin
                    a_next     = NW'(n_reg - NCW'(1));
                    final_next = 1'b0;
                    state_next = S_SHF_RD;
                end
                else
                begin
                    nbud_next  = nb_rdata;
                    sn_raddr   = d_reg;
                    state_next = S_FAN_SEEN;
                end
            end

            S_FAN_SEEN:
            begin
                if (sn_rdata)
                begin
                    state_next = S_POST_RD;
                end
                else
                begin
                    sn_we      = 1'b1;
                    sn_waddr   = d_reg;
                    sn_wdata   = 1'b1;
                    v_next     = nbud_reg;
                    state_next = S_FAN_RD;
                end
            end

            // Rotate the fan, handing each edge the color freed before it
            S_ROT_RD:
            begin
                fan_raddr  = a_reg;
                state_next = S_ROT_PAINT;
            end

            S_ROT_PAINT:
            begin
                x_next     = fv_rdata;
                pc_next    = c_reg;
                ret_next   = S_ROT_NEXT;
                state_next = S_PNT_RD;
            end

            S_ROT_NEXT:
            begin
                c_next = p_reg;
                if (a_reg == '0)
                begin
                    state_next = S_FAN_RD;
                end
                else
                begin
                    a_next     = a_reg - NW'(1);
                    state_next = S_ROT_RD;
                end
            end

            // Shift the fan: paint each edge with its own free color
            S_SHF_RD:
            begin
                fan_raddr  = a_reg;
                state_next = S_SHF_PAINT;
            end

            S_SHF_PAINT:
            begin
                x_next     = fv_rdata;
                pc_next    = fc_rdata;
                ret_next   = S_SHF_NEXT;
                state_next = S_PNT_RD;
            end

            S_SHF_NEXT:
            begin
                if (a_reg == '0)
                begin
                    state_next = final_reg ? S_ATT_END : S_FAN_RD;
                end
                else
                begin
                    a_next     = a_reg - NW'(1);
                    state_next = S_SHF_RD;
                end
            end

            S_POST_RD:
            begin
                ec_raddr   = {u_reg, v0_reg};
                state_next = S_POST_CHK;
            end

            S_POST_CHK:
            begin
                if (ec_rdata != '0)
                begin
                    state_next = S_ATT_END;
                end
                else
                begin
                    steps_next = '0;
                    state_next = S_PATH;
                end
            end

            // Walk the alternating path, swapping its two colors
            S_PATH:
            begin
                if (v_reg != '0 && steps_reg < TW'(MAX_TRIES))
                begin
                    state_next = S_INV_RD1;
                end
                else
                begin
                    state_next = S_FIX_RD;
                end
            end

            S_INV_RD1:
            begin
                nb_raddr   = {v_reg, c_reg};
                state_next = S_INV_RD2;
            end

            S_INV_RD2:
            begin
                t_next     = nb_rdata;
                nb_raddr   = {v_reg, d_reg};
                state_next = S_INV_WR1;
            end

            S_INV_WR1:
            begin
                t2_next    = nb_rdata;
                nb_we      = 1'b1;
                nb_waddr   = {v_reg, c_reg};
                nb_wdata   = nb_rdata;
                state_next = S_INV_WR2;
            end

            S_INV_WR2:
            begin
                nb_we      = 1'b1;
                nb_waddr   = {v_reg, d_reg};
                nb_wdata   = t_reg;
                state_next = (t_reg != '0) ? S_INV_EC1 : S_INV_FREE;
            end

            S_INV_EC1:
            begin
                ec_we      = 1'b1;
                ec_waddr   = {v_reg, t_reg};
                ec_wdata   = d_reg;
                state_next = S_INV_EC2;
            end

            S_INV_EC2:
            begin
                ec_we      = 1'b1;
                ec_waddr   = {t_reg, v_reg};
                ec_wdata   = d_reg;
                state_next = S_INV_FREE;
            end

            S_INV_FREE:
            begin
                if (t_reg == '0)
                begin
                    lf_we    = 1'b1;
                    lf_waddr = v_reg;
                    lf_wdata = d_reg;
                end
                else if (t2_reg == '0)
                begin
                    lf_we    = 1'b1;
                    lf_waddr = v_reg;
                    lf_wdata = c_reg;
                end
                v_next     = t_reg;
                c_next     = d_reg;
                d_next     = c_reg;
                steps_next = steps_reg + TW'(1);
                state_next = S_PATH;
            end

            // Repaint the fan tail if the first free color got taken
            S_FIX_RD:
            begin
                nb_raddr   = {u_reg, c0_reg};
                state_next = S_FIX_CHK;
            end

            S_FIX_CHK:
            begin
                if (nb_rdata != '0 && n_reg >= NCW'(2))
                begin
                    a_next     = NW'(n_reg - NCW'(2));
                    state_next = S_SRCH_RD;
                end
                else
                begin
                    state_next = S_ATT_END;
                end
            end

            S_SRCH_RD:
            begin
                fan_raddr  = a_reg;
                state_next = S_SRCH_CHK;
            end

            S_SRCH_CHK:
            begin
                if (fc_rdata == c_reg)
                begin
                    final_next = 1'b1;
                    state_next = S_SHF_RD;
                end
                else if (a_reg == '0)
                begin
                    state_next = S_ATT_END;
                end
                else
                begin
                    a_next     = a_reg - NW'(1);
                    state_next = S_SRCH_RD;
                end
            end

            S_ATT_END:
            begin
                tries_next = tries_reg + TW'(1);
                state_next = S_TRY_RD;
            end

            // Paint edge u-x with color pc, keep the old color in p
            S_PNT_RD:
            begin
                ec_raddr   = {u_reg, x_reg};
                state_next = S_PNT_GET;
            end

            S_PNT_GET:
            begin
                p_next     = ec_rdata;
                ec_we      = 1'b1;
                ec_waddr   = {u_reg, x_reg};
                ec_wdata   = pc_reg;
                state_next = S_PNT_EC2;
            end

            S_PNT_EC2:
            begin
                ec_we      = 1'b1;
                ec_waddr   = {x_reg, u_reg};
                ec_wdata   = pc_reg;
                state_next = S_PNT_NB1;
            end

            S_PNT_NB1:
            begin
                nb_we      = 1'b1;
                nb_waddr   = {u_reg, pc_reg};
                nb_wdata   = x_reg;
                state_next = S_PNT_NB2;
            end

            S_PNT_NB2:
            begin
                nb_we      = 1'b1;
                nb_waddr   = {x_reg, pc_reg};
                nb_wdata   = u_reg;
                state_next = S_PNT_NB3;
            end

            S_PNT_NB3:
            begin
                nb_we      = 1'b1;
                nb_waddr   = {u_reg, p_reg};
                state_next = S_PNT_NB4;
            end

            S_PNT_NB4:
            begin
                nb_we    = 1'b1;
                nb_waddr = {x_reg, p_reg};
                if (p_reg != '0)
                begin
                    state_next = S_PNT_LF1;
                end
                else
                begin
                    rf_w_next   = u_reg;
                    second_next = 1'b0;
                    state_next  = S_REF_RD;
                end
            end

            S_PNT_LF1:
            begin
                lf_we      = 1'b1;
                lf_waddr   = u_reg;
                lf_wdata   = p_reg;
                state_next = S_PNT_LF2;
            end

            S_PNT_LF2:
            begin
                lf_we      = 1'b1;
                lf_waddr   = x_reg;
                lf_wdata   = p_reg;
                state_next = ret_reg;
            end

            // Search the lowest free color of rf_w, one color a cycle
            S_REF_RD:
            begin
                nb_raddr   = {rf_w_reg, VW'(1)};
                rf_x_next  = VW'(1);
                state_next = S_REF_CHK;
            end

            S_REF_CHK:
            begin
                if (rf_x_reg < VW'(MAX_VERTICES) && nb_rdata != '0)
                begin
                    rf_x_next = rf_x_reg + VW'(1);
                    nb_raddr  = {rf_w_reg, rf_x_reg + VW'(1)};
                end
                else
                begin
                    lf_we    = 1'b1;
                    lf_waddr = rf_w_reg;
                    lf_wdata = rf_x_reg;
                    if (!second_reg)
                    begin
                        rf_w_next   = x_reg;
                        second_next = 1'b1;
                        state_next  = S_REF_RD;
                    end
                    else
                    begin
                        state_next = ret_reg;
                    end
                end
            end

            // Hand the result to the output register
            S_RESULT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next  = 1'b1;
                    edge_color_next = res_color_reg;
                    status_next     = res_status_reg;
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            ret_reg       <= S_IDLE;
            clr_cnt_reg   <= '0;
            respond_reg   <= 1'b0;
            tries_reg     <= '0;
            steps_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ret_reg       <= ret_next;
            clr_cnt_reg   <= clr_cnt_next;
            respond_reg   <= respond_next;
            tries_reg     <= tries_next;
            steps_reg     <= steps_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Working and result payload
    always_ff @(posedge clk)
    begin
        act_reg        <= act_next;
        u_reg          <= u_next;
        v0_reg         <= v0_next;
        v_reg          <= v_next;
        c0_reg         <= c0_next;
        c_reg          <= c_next;
        d_reg          <= d_next;
        n_reg          <= n_next;
        a_reg          <= a_next;
        x_reg          <= x_next;
        pc_reg         <= pc_next;
        p_reg          <= p_next;
        t_reg          <= t_next;
        t2_reg         <= t2_next;
        nbud_reg       <= nbud_next;
        rf_w_reg       <= rf_w_next;
        rf_x_reg       <= rf_x_next;
        second_reg     <= second_next;
        final_reg      <= final_next;
        res_color_reg  <= res_color_next;
        res_status_reg <= res_status_next;
        edge_color_reg <= edge_color_next;
        status_reg     <= status_next;
    end

    // Checks
    `VEC_ASSERT(a_busy_after_take, (in_valid && !in_stall) |=> in_stall, "block idle after take")
    `VEC_ASSERT(a_reject_blank, (out_valid && status == STAT_REJECT) |-> (edge_color == '0), "rejected pair has a color")
    `VEC_ASSERT(a_repeat_colored, (out_valid && status == STAT_REPEAT) |-> (edge_color != '0), "repeat without color")
    `VEC_ASSERT_NEVER(a_tries_bound, tries_reg > TW'(MAX_TRIES), "attempt count past bound")

endmodule

`default_nettype wire

// ----- tb/tb_top.sv -----
// ----------------------------------------------------------------------------
// Vizing edge colorer testbench
// Drives insert, read and clear transfers through the valid/stall handshakes
// and checks every result against an in-bench model of the incremental edge
// coloring, with random gaps on the input side and random stall on the output.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

import vec_pkg::*;

typedef struct {
    logic [VERTEX_W-1:0] color;
    logic [STATUS_W-1:0] stat;
} edge_result_t;

class edge_color_scoreboard;
    localparam int NV   = DEF_MAX_VERTICES;
    localparam int SPAN = NV + 1;

    int unsigned color_of[SPAN][SPAN];
    int unsigned nbr_by_color[SPAN][SPAN];
    int unsigned free_color[SPAN];
    edge_result_t expected_q[$];
    int errors;

    function new();
        errors = 0;
        wipe();
    endfunction

    function void wipe();
        for (int i = 0; i < SPAN; i++)
        begin
            free_color[i] = 1;
            for (int j = 0; j < SPAN; j++)
            begin
                color_of[i][j]     = 0;
                nbr_by_color[i][j] = 0;
            end
        end
    endfunction

    function int unsigned clamp(int unsigned x);
        return (x <= NV) ? x : 0;
    endfunction

    function void rescan_free(int unsigned u);
        int unsigned x;
        x = 1;
        u = clamp(u);
        while (x < NV && nbr_by_color[u][x] != 0)
            x++;
        free_color[u] = x;
    endfunction

    // Color edge u-v with c and return the color it had
    function int unsigned paint_edge(int unsigned u, int unsigned v, int unsigned c);
        int unsigned p;
        u = clamp(u);
        v = clamp(v);
        c = clamp(c);
        p = clamp(color_of[u][v]);
        color_of[u][v] = c;
        color_of[v][u] = c;
        nbr_by_color[u][c] = v;
        nbr_by_color[v][c] = u;
        nbr_by_color[u][p] = 0;
        nbr_by_color[v][p] = 0;
        if (p != 0)
        begin
            free_color[u] = p;
            free_color[v] = p;
        end
        else
        begin
            rescan_free(u);
            rescan_free(v);
        end
        return p;
    endfunction

    // Swap colors c1/c2 at w and advance along the path
    function int unsigned flip_step(int unsigned w, int unsigned c1, int unsigned c2);
        int unsigned p, t;
        w  = clamp(w);
        c1 = clamp(c1);
        c2 = clamp(c2);
        p = clamp(nbr_by_color[w][c1]);
        t = nbr_by_color[w][c1];
        nbr_by_color[w][c1] = nbr_by_color[w][c2];
        nbr_by_color[w][c2] = t;
        if (p != 0)
        begin
            color_of[w][p] = c2;
            color_of[p][w] = c2;
        end
        if (nbr_by_color[w][c1] == 0)
            free_color[w] = c1;
        if (nbr_by_color[w][c2] == 0)
            free_color[w] = c2;
        return p;
    endfunction

    function void fan_attempt(int unsigned u, int unsigned v0);
        int unsigned fan_v[SPAN+1];
        int unsigned fan_c[SPAN+1];
        bit seen[SPAN];
        int unsigned c0, c, v, d, n, steps, t;
        int a;
        c0 = clamp(free_color[u]);
        c = c0;
        v = v0;
        d = 0;
        n = 0;
        steps = 0;
        for (int i = 0; i < SPAN; i++)
            seen[i] = 0;
        // Grow the fan until it can be rotated
        while (color_of[u][v0] == 0 && n < SPAN + 1)
        begin
            v = clamp(v);
            d = clamp(free_color[v]);
            fan_v[n] = v;
            fan_c[n] = d;
            n++;
            if (nbr_by_color[v][c] == 0)
            begin
                for (a = int'(n) - 1; a >= 0; a--)
                    c = paint_edge(u, fan_v[a], c);
            end
            else if (nbr_by_color[u][d] == 0)
            begin
                for (a = int'(n) - 1; a >= 0; a--)
                    void'(paint_edge(u, fan_v[a], fan_c[a]));
            end
            else if (seen[d])
                break;
            else
            begin
                seen[d] = 1;
                v = clamp(nbr_by_color[u][d]);
            end
        end
        if (color_of[u][v0] != 0)
            return;
        // Invert the alternating path
        while (v != 0 && steps < 2 * SPAN)
        begin
            v = flip_step(v, c, d);
            t = c;
            c = d;
            d = t;
            steps++;
        end
        if (nbr_by_color[u][c0] != 0)
        begin
            a = int'(n) - 2;
            while (a >= 0 && fan_c[a] != c)
                a--;
            for (; a >= 0; a--)
                void'(paint_edge(u, fan_v[a], fan_c[a]));
        end
    endfunction

    // Note an accepted input transfer and queue its result
    function void note_input(logic [ACTION_W-1:0] act, logic [VERTEX_W-1:0] a,
                             logic [VERTEX_W-1:0] b);
        edge_result_t r;
        int unsigned tries;
        r.color = 0;
        r.stat  = STAT_DONE;
        if (act == ACT_CLEAR)
            wipe();
        else if (act != ACT_INSERT && act != ACT_READ)
            r.stat = STAT_DONE;
        else if (a == 0 || b == 0 || a > NV || b > NV || a == b)
            r.stat = STAT_REJECT;
        else
        begin
            if (act == ACT_INSERT)
            begin
                if (color_of[a][b] != 0)
                    r.stat = STAT_REPEAT;
                else
                    for (tries = 0; color_of[a][b] == 0 && tries < 2 * SPAN; tries++)
                        fan_attempt(a, b);
            end
            r.color = color_of[a][b][VERTEX_W-1:0];
        end
        expected_q.push_back(r);
    endfunction

    // Compare an output transfer with the oldest expectation
    function void check_result(logic [VERTEX_W-1:0] color, logic [STATUS_W-1:0] stat);
        edge_result_t e;
        if (expected_q.size() == 0)
        begin
            $display("%0t: unexpected result color=%0d status=%0d", $time, color, stat);
            errors++;
            return;
        end
        e = expected_q.pop_front();
        if (color !== e.color)
        begin
            $display("%0t: edge_color expected %0d actual %0d", $time, e.color, color);
            errors++;
        end
        if (stat !== e.stat)
        begin
            $display("%0t: status expected %0d actual %0d", $time, e.stat, stat);
            errors++;
        end
    endfunction
endclass

module tb_top;
    localparam int WATCHDOG_LIMIT = 200000;

    logic clk = 0;
    logic rst_n = 0;
    logic in_valid = 0;
    logic in_stall;
    logic [ACTION_W-1:0] action = ACT_READ;
    logic [VERTEX_W-1:0] first_vertex = 0;
    logic [VERTEX_W-1:0] second_vertex = 0;
    logic out_valid;
    logic out_stall = 0;
    logic [VERTEX_W-1:0] edge_color;
    logic [STATUS_W-1:0] status;

    edge_color_scoreboard sb = new();
    int idle_pct = 0;
    int stall_pct = 0;
    int quiet_cycles = 0;

    vizing_edge_colorer dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .action(action), .first_vertex(first_vertex), .second_vertex(second_vertex),
        .out_valid(out_valid), .out_stall(out_stall),
        .edge_color(edge_color), .status(status)
    );

    always #10 clk = ~clk;

    // Random receiver stall
    always @(posedge clk)
        out_stall <= ($urandom_range(99) < stall_pct);

    // Watch both channels and feed the scoreboard
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
                sb.note_input(action, first_vertex, second_vertex);
            if (out_valid && !out_stall)
                sb.check_result(edge_color, status);
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    task automatic send(logic [ACTION_W-1:0] act, logic [VERTEX_W-1:0] a,
                        logic [VERTEX_W-1:0] b);
        // Hold off for a random gap
        while ($urandom_range(99) < idle_pct)
        begin
            in_valid <= 0;
            @(posedge clk);
        end
        in_valid      <= 1;
        action        <= act;
        first_vertex  <= a;
        second_vertex <= b;
        do
            @(posedge clk);
        while (!(in_valid && !in_stall));
    endtask

    task automatic random_item(int span);
        int r;
        logic [ACTION_W-1:0] pick;
        r = $urandom_range(999);
        pick = ($urandom_range(1) != 0) ? ACT_READ : ACT_INSERT;
        if (r < 8)
            send(ACT_CLEAR, VERTEX_W'($urandom), VERTEX_W'($urandom));
        else if (r < 30)
            send(ACT_SPARE, VERTEX_W'($urandom), VERTEX_W'($urandom));
        else if (r < 80)
        begin
            // Broken pair: zero, out of range or a loop
            case ($urandom_range(2))
                0: send(pick, '0, VERTEX_W'($urandom_range(127)));
                1: send(pick, VERTEX_W'($urandom_range(65, 127)),
                        VERTEX_W'($urandom_range(127)));
                default:
                begin
                    r = $urandom_range(1, 64);
                    send(pick, VERTEX_W'(r), VERTEX_W'(r));
                end
            endcase
        end
        else
        begin
            logic [VERTEX_W-1:0] a, b;
            a = VERTEX_W'($urandom_range(1, span));
            b = VERTEX_W'($urandom_range(1, span - 1));
            if (b >= a)
                b++;
            send((r < 280) ? ACT_READ : ACT_INSERT, a, b);
        end
    endtask

    initial
    begin
        int spans[4] = '{5, 9, 16, 64};
        int span;
        repeat (4) @(posedge clk);
        rst_n <= 1;

        // Directed: triangle, repeats, reads, rejects, unused action, clear
        send(ACT_READ, 1, 2);
        send(ACT_INSERT, 1, 2);
        send(ACT_INSERT, 2, 3);
        send(ACT_INSERT, 1, 3);
        send(ACT_INSERT, 3, 1);
        send(ACT_READ, 3, 2);
        send(ACT_INSERT, 64, 1);
        send(ACT_INSERT, 63, 64);
        send(ACT_INSERT, 1, 63);
        send(ACT_INSERT, 2, 64);
        send(ACT_READ, 64, 1);
        send(ACT_INSERT, 0, 5);
        send(ACT_READ, 5, 0);
        send(ACT_INSERT, 7, 7);
        send(ACT_INSERT, 65, 3);
        send(ACT_READ, 127, 127);
        send(ACT_INSERT, 1, 127);
        send(ACT_SPARE, 127, 0);
        send(ACT_CLEAR, 0, 0);
        send(ACT_READ, 1, 2);
        send(ACT_INSERT, 2, 1);

        // Random phases: free flow, sender gaps, receiver stall, both
        for (int ph = 0; ph < 4; ph++)
        begin
            idle_pct  = (ph == 1) ? 58 : (ph == 3) ? 28 : 0;
            stall_pct = (ph == 2) ? 58 : (ph == 3) ? 28 : 0;
            span = spans[$urandom_range(3)];
            for (int i = 0; i < 140; i++)
            begin
                if (i % 35 == 0)
                    span = spans[$urandom_range(3)];
                random_item(span);
            end
        end
        in_valid <= 0;

        while (sb.expected_q.size() != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
        if (sb.errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end
endmodule
